/* design/pios_pkg.sv */
// ----------------------------------------------------------------------------
// pios_pkg: shared types and constants for the periodic image overlap block
// Candidate masks, result record, queue geometry and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pios_pkg;

  localparam int PIOS_COORD_BITS = 16;
  localparam int LEN_W           = 15;
  localparam int SHIFT_W         = 16;
  localparam int MASK_W          = 3;

  // one bit per shift vector, index = (ri+1)*9 + (rj+1)*3 + (rk+1)
  localparam int NUM_CAND   = 27;
  localparam int CENTER_IDX = 13;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [NUM_CAND-1:0] cand_t;

  // candidate positions with a given component at -1 or +1
  localparam cand_t RX_NEG = 27'h00001FF;
  localparam cand_t RX_POS = 27'h7FC0000;
  localparam cand_t RY_NEG = 27'h01C0E07;
  localparam cand_t RY_POS = 27'h70381C0;
  localparam cand_t RZ_NEG = 27'h1249249;
  localparam cand_t RZ_POS = 27'h4924924;

  typedef enum logic [1:0] {
    REG_PERIODIC_MASK = 2'd0,
    REG_DOMAIN_LEN_X  = 2'd1,
    REG_DOMAIN_LEN_Y  = 2'd2,
    REG_DOMAIN_LEN_Z  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                      strobe;
    logic                      found;
    logic signed [SHIFT_W-1:0] shift_x;
    logic signed [SHIFT_W-1:0] shift_y;
    logic signed [SHIFT_W-1:0] shift_z;
    logic                      last;
  } result_t;

endpackage

`default_nettype wire

/* design/pios_front.sv */
// ----------------------------------------------------------------------------
// pios_front: box registration and candidate classification
// Registers an accepted item, tests each axis against the three images of
// the source and pushes the 27-bit mask of overlapping nonzero shift vectors.
// ----------------------------------------------------------------------------
`default_nettype none

module pios_front import pios_pkg::*; #(
  parameter int COORD_BITS = PIOS_COORD_BITS
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         accept,
  input  wire  [2:0][COORD_BITS-1:0]  tlo_in,
  input  wire  [2:0][COORD_BITS-1:0]  thi_in,
  input  wire  [2:0][COORD_BITS-1:0]  slo_in,
  input  wire  [2:0][COORD_BITS-1:0]  shi_in,
  input  wire  [MASK_W-1:0]           periodic_mask,
  input  wire  [2:0][LEN_W-1:0]       domain_len,
  output logic                        push,
  output cand_t                       push_mask
);

  localparam int SUM_W = ((COORD_BITS > LEN_W + 1) ? COORD_BITS : LEN_W + 1) + 2;

  logic [2:0][COORD_BITS-1:0] tlo, thi, slo, shi;
  logic                       s1_valid;

  logic signed [SUM_W-1:0] ext_tlo [3];
  logic signed [SUM_W-1:0] ext_thi [3];
  logic signed [SUM_W-1:0] ext_slo [3];
  logic signed [SUM_W-1:0] ext_shi [3];
  logic signed [SUM_W-1:0] off     [3][3];
  logic        [2:0]       axis_ok [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tlo <= tlo_in;
      thi <= thi_in;
      slo <= slo_in;
      shi <= shi_in;
    end
  end

  // axis_ok[a][r]: image at offset (r-1)*len overlaps target on axis a
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ext_tlo[a] = {{(SUM_W-COORD_BITS){tlo[a][COORD_BITS-1]}}, tlo[a]};
      ext_thi[a] = {{(SUM_W-COORD_BITS){thi[a][COORD_BITS-1]}}, thi[a]};
      ext_slo[a] = {{(SUM_W-COORD_BITS){slo[a][COORD_BITS-1]}}, slo[a]};
      ext_shi[a] = {{(SUM_W-COORD_BITS){shi[a][COORD_BITS-1]}}, shi[a]};
      off[a][1]  = '0;
      off[a][2]  = {{(SUM_W-LEN_W){1'b0}}, domain_len[a]};
      off[a][0]  = -off[a][2];
      for (int r = 0; r < 3; r++) begin
        axis_ok[a][r] = (r == 1 || periodic_mask[a])
                        && (ext_tlo[a] <= ext_thi[a])
                        && (ext_slo[a] <= ext_shi[a])
                        && (ext_tlo[a] <= ext_shi[a] + off[a][r])
                        && (ext_slo[a] + off[a][r] <= ext_thi[a]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CAND; i++) begin
      push_mask[i] = axis_ok[0][i / 9] & axis_ok[1][(i / 3) % 3] & axis_ok[2][i % 3];
    end
    push_mask[CENTER_IDX] = 1'b0;
  end

  assign push = s1_valid;

endmodule

`default_nettype wire

/* design/pios_queue.sv */
// ----------------------------------------------------------------------------
// pios_queue: candidate mask queue
// Short FIFO between classification and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module pios_queue import pios_pkg::*; (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  cand_t             push_mask,
  input  wire               pop,
  output cand_t             head_mask,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  cand_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_mask;
    end
  end

  assign head_mask = entries[rd_ptr];
  assign empty     = (count == '0);

endmodule

`default_nettype wire

/* design/pios_back.sv */
// ----------------------------------------------------------------------------
// pios_back: result emission
// Walks the head mask lowest index first, one result per cycle, and
// retires the item with its last result.
// ----------------------------------------------------------------------------
`default_nettype none

module pios_back import pios_pkg::*; (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   empty,
  input  cand_t                 head_mask,
  input  wire  [2:0][LEN_W-1:0] domain_len,
  output logic                  pop,
  output result_t               result
);

  cand_t   done, done_next;
  cand_t   cur, sel, rest;
  result_t result_next;

  function automatic logic signed [SHIFT_W-1:0] shift_of(
    input logic neg, input logic pos, input logic [LEN_W-1:0] len
  );
    logic signed [SHIFT_W-1:0] mag;
    mag = {{(SHIFT_W-LEN_W){1'b0}}, len};
    if (pos) begin
      return mag;
    end else if (neg) begin
      return -mag;
    end
    return '0;
  endfunction

  always_comb begin
    cur       = head_mask & ~done;
    sel       = cur & (~cur + cand_t'(1));
    rest      = cur & ~sel;
    pop       = !empty && (rest == '0);
    done_next = done;
    if (!empty) begin
      done_next = pop ? '0 : (done | sel);
    end

    result_next.strobe  = !empty;
    result_next.found   = (cur != '0);
    result_next.last    = (rest == '0);
    result_next.shift_x = shift_of(|(sel & RX_NEG), |(sel & RX_POS), domain_len[0]);
    result_next.shift_y = shift_of(|(sel & RY_NEG), |(sel & RY_POS), domain_len[1]);
    result_next.shift_z = shift_of(|(sel & RZ_NEG), |(sel & RZ_POS), domain_len[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= '0;
      result <= '0;
    end else begin
      done   <= done_next;
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

/* design/periodic_image_overlap_shifts.sv */
// ----------------------------------------------------------------------------
// periodic_image_overlap_shifts: shifts of periodic source images that hit
// a target box
//
// An item (target and source box, inclusive corners) is taken at a clock
// edge with start high and busy low. busy is high while the mask queue is
// full or its last free slot is held for the item in the classify stage.
// Results come out on found/shift_x/y/z/last, each valid for exactly the
// one cycle in which strobe is high; last marks the final result of an
// item. An item with no overlapping image gives one result with found low
// and last high.
// When the emitter is free, an item is registered in the front, its mask
// in the queue and its first result in the result register. The emitter
// gives one result per cycle, max(n, 1) per item, n being its number of
// overlapping images (at most 26); the front takes an item every cycle
// while the queue has room. Configuration (cfg_we, cfg_index, cfg_data)
// is to be written by the user only while idle; the block itself does not
// enforce it. Reset clears the queue and emitter and restores the register
// defaults. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_image_overlap_shifts import pios_pkg::*; #(
  parameter int COORD_BITS = PIOS_COORD_BITS
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  wire signed [COORD_BITS-1:0] target_lo_x,
  input  wire signed [COORD_BITS-1:0] target_lo_y,
  input  wire signed [COORD_BITS-1:0] target_lo_z,
  input  wire signed [COORD_BITS-1:0] target_hi_x,
  input  wire signed [COORD_BITS-1:0] target_hi_y,
  input  wire signed [COORD_BITS-1:0] target_hi_z,
  input  wire signed [COORD_BITS-1:0] src_lo_x,
  input  wire signed [COORD_BITS-1:0] src_lo_y,
  input  wire signed [COORD_BITS-1:0] src_lo_z,
  input  wire signed [COORD_BITS-1:0] src_hi_x,
  input  wire signed [COORD_BITS-1:0] src_hi_y,
  input  wire signed [COORD_BITS-1:0] src_hi_z,
  output logic                        strobe,
  output logic                        found,
  output logic signed [SHIFT_W-1:0]   shift_x,
  output logic signed [SHIFT_W-1:0]   shift_y,
  output logic signed [SHIFT_W-1:0]   shift_z,
  output logic                        last,
  input  wire                         cfg_we,
  input  wire  [1:0]                  cfg_index,
  input  wire  [LEN_W-1:0]            cfg_data
);

  logic [MASK_W-1:0]     periodic_mask;
  logic [2:0][LEN_W-1:0] domain_len;

  logic              accept;
  logic              push, pop, empty;
  cand_t             push_mask, head_mask;
  logic [QCNT_W-1:0] count;
  result_t           result;

  always_ff @(posedge clk) begin
    if (rst) begin
      periodic_mask <= '0;
      domain_len    <= {3{LEN_W'(64)}};
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PERIODIC_MASK: periodic_mask <= cfg_data[MASK_W-1:0];
        REG_DOMAIN_LEN_X:  domain_len[0] <= cfg_data;
        REG_DOMAIN_LEN_Y:  domain_len[1] <= cfg_data;
        REG_DOMAIN_LEN_Z:  domain_len[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // leave room for the item still in the classify stage
  assign busy   = ({1'b0, count} + (QCNT_W+1)'(push)) >= (QCNT_W+1)'(QUEUE_DEPTH);
  assign accept = start && !busy;

  pios_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .tlo_in        ({target_lo_z, target_lo_y, target_lo_x}),
    .thi_in        ({target_hi_z, target_hi_y, target_hi_x}),
    .slo_in        ({src_lo_z, src_lo_y, src_lo_x}),
    .shi_in        ({src_hi_z, src_hi_y, src_hi_x}),
    .periodic_mask (periodic_mask),
    .domain_len    (domain_len),
    .push          (push),
    .push_mask     (push_mask)
  );

  pios_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_mask (push_mask),
    .pop       (pop),
    .head_mask (head_mask),
    .empty     (empty),
    .count     (count)
  );

  pios_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .head_mask  (head_mask),
    .domain_len (domain_len),
    .pop        (pop),
    .result     (result)
  );

  assign strobe  = result.strobe;
  assign found   = result.found;
  assign shift_x = result.shift_x;
  assign shift_y = result.shift_y;
  assign shift_z = result.shift_z;
  assign last    = result.last;

endmodule

`default_nettype wire
